>>> hdl/touch_pad_click_mapper_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef TOUCH_PAD_CLICK_MAPPER_MACROS_SVH
`define TOUCH_PAD_CLICK_MAPPER_MACROS_SVH

// property checked on every rising edge outside reset
`define TPCM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication outside reset
`define TPCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/tpcm_pkg.sv
// types and constants of the touch pad click mapper
// no dependencies
package tpcm_pkg;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_LEFT        = 3'd1,
    ACT_RIGHT       = 3'd2,
    ACT_MIDDLE      = 3'd3,
    ACT_SCROLL_UP   = 3'd4,
    ACT_SCROLL_DOWN = 3'd5,
    ACT_CLUTCH      = 3'd6,
    ACT_SCROLL_MODE = 3'd7
  } action_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MODIFIER = 2'd0;
  localparam cfg_idx_t CFG_PRIMARY  = 2'd1;
  localparam cfg_idx_t CFG_ALT      = 2'd2;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;

  localparam logic [2:0] BTN_NONE   = 3'b000;
  localparam logic [2:0] BTN_LEFT   = 3'b001;
  localparam logic [2:0] BTN_RIGHT  = 3'b010;
  localparam logic [2:0] BTN_MIDDLE = 3'b100;

  localparam logic signed [1:0] WHEEL_NONE = 2'sb00;
  localparam logic signed [1:0] WHEEL_UP   = 2'sb01;
  localparam logic signed [1:0] WHEEL_DOWN = 2'sb11;

  localparam logic [2:0] MOD_NONE  = 3'd7;
  localparam int unsigned ALT_SLOTS = 3;

  // one result item as it sits in the output register
  typedef struct packed {
    logic              report_valid;
    logic [2:0]        button_bits;
    logic signed [1:0] wheel_step;
    logic              clutch_on;
    logic              scroll_mode_on;
  } result_t;

endpackage

>>> hdl/touch_pad_click_mapper.sv
// touch pad click mapper: pad press/release events to mouse button reports
// depends on tpcm_pkg
//
// usage:
//   in_*  : one pad event per request; in_tdata holds pad_index in bits 2:0,
//           in_tuser holds event_kind in bits 1:0 and asleep in bit 2
//   out_* : one result per event; out_tuser[0] is report_valid, out_tdata
//           holds button_bits, wheel_step, clutch_on, scroll_mode_on
//   cfg_* : register writes (modifier pad, primary actions, alternate
//           actions), taken at any edge with cfg_we high; the user writes
//           them only while idle, which the block itself does not enforce
// path: an accepted event goes through the input then the result register
// throughput: one event per cycle while the output is not stalled; the
//   held mask, button bits and flags update between input and result registers
// reset: synchronous active-low rst_n clears both pipeline valid bits, the
//   held mask, buttons, flags and cfg registers (modifier pad reads as none)
// stall: while out_tready is low the result holds; the input register
//   takes one more request only if it is empty, then in_tready drops
module touch_pad_click_mapper
  import tpcm_pkg::*;
#(
  parameter int unsigned PAD_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] pad_index, [7:3] zero
  input  logic [2:0]  in_tuser,   // [1:0] event_kind, [2] asleep
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] button_bits, [4:3] wheel_step, [5] clutch_on,
  // [6] scroll_mode_on, [7] zero
  output logic [7:0]  out_tdata,
  output logic [0:0]  out_tuser,  // [0] report_valid
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [11:0] cfg_wdata
);

  // configuration
  logic [2:0]       mod_pad_r;
  logic [3:0][2:0]  primary_r;
  logic [2:0][2:0]  alt_r;

  // input register
  logic             in_valid_r;
  logic [1:0]       in_kind_r;
  logic [2:0]       in_pad_r;
  logic             in_asleep_r;

  // block state
  logic [PAD_COUNT-1:0] held_r, held_nxt;
  logic [2:0]           buttons_r, buttons_nxt;
  logic                 clutch_r, clutch_nxt;
  logic                 scroll_r, scroll_nxt;

  // result register
  logic             out_valid_r;
  result_t          res_r, res_nxt;

  logic             advance;
  logic             ev_ok;
  logic             press;
  logic             is_mod;
  logic             mod_held;
  logic [PAD_COUNT-1:0] pad_bit;
  logic [PAD_COUNT-1:0] mod_bit;
  logic [PAD_COUNT-1:0] held_upd;
  logic [2:0]       slot;
  action_t          prim_act;
  action_t          alt_act;
  action_t          act;
  logic [2:0]       btn_mask;
  logic             report;
  logic signed [1:0] wheel;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_pad_r <= MOD_NONE;
      primary_r <= '0;
      alt_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODIFIER: mod_pad_r <= cfg_wdata[2:0];
        CFG_PRIMARY:  primary_r <= cfg_wdata[11:0];
        CFG_ALT:      alt_r     <= cfg_wdata[8:0];
        default:      ;
      endcase
    end
  end

  // event decode
  always_comb begin
    ev_ok    = !in_asleep_r && (in_kind_r == KIND_PRESS || in_kind_r == KIND_RELEASE)
               && (in_pad_r < 3'(PAD_COUNT));
    press    = (in_kind_r == KIND_PRESS);
    is_mod   = (in_pad_r == mod_pad_r);
    pad_bit  = PAD_COUNT'(1) << in_pad_r;
    // modifier outside the pad range shifts out to zero: never held
    mod_bit  = PAD_COUNT'(1) << mod_pad_r;
    held_upd = press ? (held_r | pad_bit) : (held_r & ~pad_bit);
    mod_held = |(held_upd & mod_bit);

    // alternate slot skips the modifier's position
    slot     = (in_pad_r < mod_pad_r) ? in_pad_r : in_pad_r - 3'd1;
    prim_act = action_t'(primary_r[in_pad_r[1:0]]);
    case (slot)
      3'd0:    alt_act = action_t'(alt_r[0]);
      3'd1:    alt_act = action_t'(alt_r[1]);
      3'd2:    alt_act = action_t'(alt_r[2]);
      default: alt_act = ACT_NONE;
    endcase
    act = mod_held ? alt_act : prim_act;
  end

  // action effects
  always_comb begin
    held_nxt    = held_r;
    buttons_nxt = buttons_r;
    clutch_nxt  = clutch_r;
    scroll_nxt  = scroll_r;
    btn_mask    = BTN_NONE;
    report      = 1'b0;
    wheel       = WHEEL_NONE;
    if (ev_ok) begin
      held_nxt = held_upd;
      if (!is_mod) begin
        case (act)
          ACT_LEFT:   btn_mask = BTN_LEFT;
          ACT_RIGHT:  btn_mask = BTN_RIGHT;
          ACT_MIDDLE: btn_mask = BTN_MIDDLE;
          ACT_SCROLL_UP: begin
            report = press;
            wheel  = press ? WHEEL_UP : WHEEL_NONE;
          end
          ACT_SCROLL_DOWN: begin
            report = press;
            wheel  = press ? WHEEL_DOWN : WHEEL_NONE;
          end
          ACT_CLUTCH:      clutch_nxt = press;
          ACT_SCROLL_MODE: scroll_nxt = press;
          default:         ;
        endcase
        if (btn_mask != BTN_NONE) begin
          buttons_nxt = press ? (buttons_r | btn_mask) : (buttons_r & ~btn_mask);
          report      = 1'b1;
        end
      end
    end
    res_nxt.report_valid   = report;
    res_nxt.button_bits    = buttons_nxt;
    res_nxt.wheel_step     = wheel;
    res_nxt.clutch_on      = clutch_nxt;
    res_nxt.scroll_mode_on = scroll_nxt;
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      buttons_r   <= '0;
      clutch_r    <= 1'b0;
      scroll_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        held_r      <= held_nxt;
        buttons_r   <= buttons_nxt;
        clutch_r    <= clutch_nxt;
        scroll_r    <= scroll_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r   <= in_tuser[1:0];
      in_pad_r    <= in_tdata[2:0];
      in_asleep_r <= in_tuser[2];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.report_valid;
  assign out_tdata  = {1'b0, res_r.scroll_mode_on, res_r.clutch_on,
                       res_r.wheel_step, res_r.button_bits};

endmodule

>>> hdl/tpcm_checker.sv
// port-level checks for the touch pad click mapper, bound to the top level
// depends on touch_pad_click_mapper_macros.svh
`include "touch_pad_click_mapper_macros.svh"

module tpcm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser
);

  // a stalled result keeps its payload
  `TPCM_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // wheel movement only comes with a report
  `TPCM_ASSERT_IMP(a_wheel_report, clk, rst_n, out_tvalid && out_tdata[4:3] != 2'b00, out_tuser[0], "wheel step without report")

  // wheel step is one of -1, 0, +1
  `TPCM_ASSERT_IMP(a_wheel_range, clk, rst_n, out_tvalid, out_tdata[4:3] != 2'b10, "wheel step out of range")

  // a request followed by a ready output leads to a valid result
  `TPCM_ASSERT(a_latency, clk, rst_n, (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid, "result missing after request")

endmodule

bind touch_pad_click_mapper tpcm_checker u_tpcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
